FILE: hw/rtl/urtrb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the UART receive/transmit ring buffers.
// No dependencies; imported by the top level and the checker.
package urtrb_pkg;

    localparam int DEPTH   = 64;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int LEN_W   = 7;
    localparam int COUNT_W = 7;
    localparam int CMP_W   = (FILL_W > LEN_W) ? FILL_W : LEN_W;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        CMD_LINE_RX  = 3'd0,
        CMD_HOST_RD  = 3'd1,
        CMD_WR_CHECK = 3'd2,
        CMD_WR_BYTE  = 3'd3,
        CMD_TX_READY = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_CLOSED = 2'd1,
        ST_NOROOM = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // first member sits in the top bits
    typedef struct packed {
        logic                tx_active;
        logic [COUNT_W-1:0]  tx_count;
        logic [COUNT_W-1:0]  rx_count;
        logic                overrun;
        logic [7:0]          tx_byte;
        logic                tx_valid;
        logic [7:0]          rd_data;
        t_status             status;
    } t_result;

    localparam int RES_W = $bits(t_result);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: hw/rtl/uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps
// UART receive/transmit ring buffers: command register, state update, result register.
// Depends on urtrb_pkg.
// A request is held in the request register until the result register can take it;
// its result is then registered there and offered on the result stream.
// Throughput: one request per cycle; the input and result registers are both
// held only while the result side stalls.
// Reset (synchronous, active low) empties both rings, clears the overrun flag,
// idles the transmitter and closes the port. Ring contents are not cleared.
module uart_rx_tx_ring_buffers (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: port_open
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] data, [14:8] msg_len, [15] zero
    input  logic [urtrb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [2:0] cmd
    input  logic [2:0]                        s_axis_tuser,
    input  logic                              s_axis_tlast,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] status, [9:2] rd_data, [10] tx_valid, [18:11] tx_byte, [19] overrun,
    // [26:20] rx_count, [33:27] tx_count, [34] tx_active, [39:35] zero
    output logic [urtrb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import urtrb_pkg::*;

    // request register
    logic              r_a_valid;
    logic [2:0]        r_a_cmd;
    logic [7:0]        r_a_data;
    logic [LEN_W-1:0]  r_a_len;
    logic              r_a_last;

    // result register
    logic              r_b_valid;
    t_result           r_b_res;

    // ring state
    logic [7:0]        r_rx_mem [DEPTH];
    logic [7:0]        r_tx_mem [DEPTH];
    logic [PTR_W-1:0]  r_rx_head, r_rx_tail, r_tx_head, r_tx_tail;
    logic [FILL_W-1:0] r_rx_fill, r_tx_fill;
    logic [7:0]        r_rx_front, r_tx_front;  // store[tail], kept registered
    logic              r_tx_on, r_overrun, r_port_open;

    logic [PTR_W-1:0]  n_rx_head, n_rx_tail, n_tx_head, n_tx_tail;
    logic [FILL_W-1:0] n_rx_fill, n_tx_fill;
    logic              n_tx_on, n_overrun;
    t_result           n_res;

    logic advance;
    logic rx_push, rx_pop, tx_push, tx_pop;
    logic rx_fwd, tx_fwd;

    assign advance       = r_a_valid && (!r_b_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), r_b_res};

    always_comb begin
        rx_push   = 1'b0;
        rx_pop    = 1'b0;
        tx_push   = 1'b0;
        tx_pop    = 1'b0;
        n_tx_on   = r_tx_on;
        n_overrun = r_overrun;
        n_res     = '0;
        n_res.status = ST_OK;

        case (r_a_cmd)
            CMD_LINE_RX: begin
                if (r_rx_fill < FILL_W'(DEPTH)) begin
                    rx_push = 1'b1;
                end else begin
                    n_overrun    = 1'b1;
                    n_res.status = ST_NOROOM;
                end
            end
            CMD_HOST_RD: begin
                if (!r_port_open) begin
                    n_res.status = ST_CLOSED;
                end else if (r_rx_fill == '0) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    rx_pop        = 1'b1;
                    n_res.rd_data = r_rx_front;
                end
            end
            CMD_WR_CHECK: begin
                if (!r_port_open) begin
                    n_res.status = ST_CLOSED;
                end else if (CMP_W'(r_a_len) > CMP_W'(DEPTH) - CMP_W'(r_tx_fill)) begin
                    n_res.status = ST_NOROOM;
                end
            end
            CMD_WR_BYTE: begin
                if (!r_port_open) begin
                    n_res.status = ST_CLOSED;
                end else begin
                    if (r_tx_fill < FILL_W'(DEPTH)) begin
                        tx_push = 1'b1;
                    end else begin
                        n_res.status = ST_NOROOM;
                    end
                    // kick: ring is never empty after the push, so a byte always goes out
                    if (r_a_last && !r_tx_on) begin
                        n_tx_on        = 1'b1;
                        tx_pop         = 1'b1;
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = (r_tx_fill == '0) ? r_a_data : r_tx_front;
                    end
                end
            end
            CMD_TX_READY: begin
                if (r_tx_on) begin
                    if (r_tx_fill != '0) begin
                        tx_pop         = 1'b1;
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = r_tx_front;
                    end else begin
                        n_tx_on = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        n_rx_head = rx_push ? ptr_inc(r_rx_head) : r_rx_head;
        n_rx_tail = rx_pop  ? ptr_inc(r_rx_tail) : r_rx_tail;
        n_tx_head = tx_push ? ptr_inc(r_tx_head) : r_tx_head;
        n_tx_tail = tx_pop  ? ptr_inc(r_tx_tail) : r_tx_tail;
        n_rx_fill = r_rx_fill + FILL_W'(rx_push) - FILL_W'(rx_pop);
        n_tx_fill = r_tx_fill + FILL_W'(tx_push) - FILL_W'(tx_pop);

        n_res.overrun   = n_overrun;
        n_res.rx_count  = COUNT_W'(n_rx_fill);
        n_res.tx_count  = COUNT_W'(n_tx_fill);
        n_res.tx_active = n_tx_on;
    end

    // a write landing on the next front entry is forwarded past the memory
    assign rx_fwd = advance && rx_push && (r_rx_head == n_rx_tail);
    assign tx_fwd = advance && tx_push && (r_tx_head == n_tx_tail);

    always_ff @(posedge i_clk) begin
        if (advance && rx_push) begin
            r_rx_mem[r_rx_head] <= r_a_data;
        end
        if (advance && tx_push) begin
            r_tx_mem[r_tx_head] <= r_a_data;
        end
        r_rx_front <= rx_fwd ? r_a_data : r_rx_mem[advance ? n_rx_tail : r_rx_tail];
        r_tx_front <= tx_fwd ? r_a_data : r_tx_mem[advance ? n_tx_tail : r_tx_tail];
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_a_cmd  <= s_axis_tuser;
            r_a_data <= s_axis_tdata[7:0];
            r_a_len  <= s_axis_tdata[14:8];
            r_a_last <= s_axis_tlast;
        end
        if (advance) begin
            r_b_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_fill   <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_fill   <= '0;
            r_tx_on     <= 1'b0;
            r_overrun   <= 1'b0;
            r_port_open <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_a_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_b_valid <= 1'b1;
                r_rx_head <= n_rx_head;
                r_rx_tail <= n_rx_tail;
                r_rx_fill <= n_rx_fill;
                r_tx_head <= n_tx_head;
                r_tx_tail <= n_tx_tail;
                r_tx_fill <= n_tx_fill;
                r_tx_on   <= n_tx_on;
                r_overrun <= n_overrun;
            end else if (m_axis_tready) begin
                r_b_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_port_open <= i_cfg_data;
            end
        end
    end

endmodule

FILE: hw/rtl/urtrb_chk.sv
`timescale 1ns / 1ps
// Port-level checks for uart_rx_tx_ring_buffers, attached by bind.
// Depends on urtrb_pkg.
module urtrb_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [urtrb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import urtrb_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no byte to the transmitter unless it is running afterwards
    a_tx_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[34])
        else $error("tx byte while transmitter idle");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[10] |-> m_axis_tdata[18:11] == 8'd0)
        else $error("tx_byte set without tx_valid");

    // a popped byte only comes with status ok
    a_rd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[9:2] == 8'd0)
        else $error("rd_data set on failed request");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[26:20] <= COUNT_W'(DEPTH)
                          && m_axis_tdata[33:27] <= COUNT_W'(DEPTH))
        else $error("ring count beyond depth");

endmodule

bind uart_rx_tx_ring_buffers urtrb_chk u_urtrb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/tb_uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps
// Self-checking testbench for uart_rx_tx_ring_buffers: directed table, then random command mix.
// Depends on urtrb_pkg and the RTL top level; results are predicted by a behavioural ring model.
module tb_uart_rx_tx_ring_buffers;
    import urtrb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 1300;
    localparam int MAX_REPORTS = 100;
    localparam int IDLE_PCT    = 17;

    // command codes with no function in the block
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REQ,
        ROW_REQ_FIXED
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  cmd;
        logic [7:0]  data;
        logic [6:0]  len;
        logic        last;
        int          reps;
        t_result     want;
    } t_stim_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data    = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [2:0]             s_axis_tuser  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    // behavioural copy of the rings
    logic [7:0] rx_bytes [DEPTH];
    logic [7:0] tx_bytes [DEPTH];
    int         rx_wr, rx_rd, rx_level;
    int         tx_wr, tx_rd, tx_level;
    logic       tx_running, rx_overflowed, port_is_open;

    t_result    pending_results[$];
    t_result    last_pred;
    t_stim_row  stim_rows[$];

    bit         steady = 1'b0;
    int         n_sent, n_checked, n_errors, n_tx_bytes, n_drops, n_reads;
    int         cycle_count;

    uart_rx_tx_ring_buffers u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result make_result(t_status st, logic [7:0] rd, logic txv,
                                            logic [7:0] txb, logic ovr, logic [6:0] rxc,
                                            logic [6:0] txc, logic act);
        t_result r;
        r.status    = st;
        r.rd_data   = rd;
        r.tx_valid  = txv;
        r.tx_byte   = txb;
        r.overrun   = ovr;
        r.rx_count  = rxc;
        r.tx_count  = txc;
        r.tx_active = act;
        return r;
    endfunction

    // advances the ring copy by one request and returns what the block should emit
    function automatic t_result step_rings(logic [2:0] cmd, logic [7:0] data,
                                           logic [6:0] len, logic last);
        t_result r;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_LINE_RX: begin
                if (rx_level == DEPTH) begin
                    rx_overflowed = 1'b1;
                    r.status = ST_NOROOM;
                end else begin
                    rx_bytes[rx_wr] = data;
                    rx_wr = (rx_wr + 1) % DEPTH;
                    rx_level++;
                end
            end
            CMD_HOST_RD: begin
                if (!port_is_open) begin
                    r.status = ST_CLOSED;
                end else if (rx_level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.rd_data = rx_bytes[rx_rd];
                    rx_rd = (rx_rd + 1) % DEPTH;
                    rx_level--;
                end
            end
            CMD_WR_CHECK: begin
                if (!port_is_open)
                    r.status = ST_CLOSED;
                else if (DEPTH - tx_level < int'(len))
                    r.status = ST_NOROOM;
            end
            CMD_WR_BYTE: begin
                if (!port_is_open) begin
                    r.status = ST_CLOSED;
                end else begin
                    if (tx_level == DEPTH) begin
                        r.status = ST_NOROOM;
                    end else begin
                        tx_bytes[tx_wr] = data;
                        tx_wr = (tx_wr + 1) % DEPTH;
                        tx_level++;
                    end
                    // kick an idle transmitter; the ring is never empty here
                    if (last && !tx_running) begin
                        tx_running = 1'b1;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = tx_bytes[tx_rd];
                        tx_rd = (tx_rd + 1) % DEPTH;
                        tx_level--;
                    end
                end
            end
            CMD_TX_READY: begin
                if (tx_running) begin
                    if (tx_level != 0) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = tx_bytes[tx_rd];
                        tx_rd = (tx_rd + 1) % DEPTH;
                        tx_level--;
                    end else begin
                        tx_running = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        r.overrun   = rx_overflowed;
        r.rx_count  = 7'(rx_level);
        r.tx_count  = 7'(tx_level);
        r.tx_active = tx_running;
        return r;
    endfunction

    function automatic void add_row(t_row_kind kind, logic [2:0] cmd, logic [7:0] data,
                                    logic [6:0] len, logic last, int reps, t_result want);
        t_stim_row row;
        row.kind = kind;
        row.cmd  = cmd;
        row.data = data;
        row.len  = len;
        row.last = last;
        row.reps = reps;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    // one request through the slave port; the prediction is taken at the accepting edge
    task automatic send_req(logic [2:0] cmd, logic [7:0] data, logic [6:0] len, logic last,
                            bit fixed = 1'b0, t_result want = '0);
        t_result pred;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, len, data};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pred = step_rings(cmd, data, len, last);
        last_pred = pred;
        pending_results.push_back(fixed ? want : pred);
        n_sent++;
        if (pred.tx_valid)
            n_tx_bytes++;
        if (cmd == CMD_LINE_RX && pred.status == ST_NOROOM)
            n_drops++;
        if (cmd == CMD_HOST_RD && pred.status == ST_OK)
            n_reads++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // only called with nothing in flight
    task automatic write_port_open(logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        port_is_open = value;
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[RES_W-1:0]);
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $error("result with no request outstanding: %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("status",    want.status,    got.status);
                check_field("rd_data",   want.rd_data,   got.rd_data);
                check_field("tx_valid",  want.tx_valid,  got.tx_valid);
                check_field("tx_byte",   want.tx_byte,   got.tx_byte);
                check_field("overrun",   want.overrun,   got.overrun);
                check_field("rx_count",  want.rx_count,  got.rx_count);
                check_field("tx_count",  want.tx_count,  got.tx_count);
                check_field("tx_active", want.tx_active, got.tx_active);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_stim_row  row;
        int         base, phase, phase_len, phase_end, n, k, sel;
        bit         broken;
        logic       lst;

        rx_wr = 0; rx_rd = 0; rx_level = 0;
        tx_wr = 0; tx_rd = 0; tx_level = 0;
        tx_running = 1'b0; rx_overflowed = 1'b0; port_is_open = 1'b0;
        n_sent = 0; n_checked = 0; n_errors = 0; n_tx_bytes = 0; n_drops = 0; n_reads = 0;

        // port closed after reset
        add_row(ROW_REQ_FIXED, CMD_HOST_RD, 8'h00, 7'd0, 1'b0, 1,
                make_result(ST_CLOSED, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_WR_CHECK, 8'h00, 7'd0, 1'b0, 1,
                make_result(ST_CLOSED, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_WR_BYTE, 8'hFF, 7'd0, 1'b1, 1,
                make_result(ST_CLOSED, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_TX_READY, 8'h00, 7'd0, 1'b0, 1,
                make_result(ST_OK, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 1'b0));
        // line receive ignores the port state; fill the ring then overflow it
        add_row(ROW_REQ, CMD_LINE_RX, 8'h00, 7'd0, 1'b0, DEPTH, '0);
        add_row(ROW_REQ_FIXED, CMD_LINE_RX, 8'hFF, 7'd127, 1'b1, 1,
                make_result(ST_NOROOM, 8'h00, 1'b0, 8'h00, 1'b1, 7'd64, 7'd0, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_HOST_RD, 8'h00, 7'd0, 1'b0, 1,
                make_result(ST_CLOSED, 8'h00, 1'b0, 8'h00, 1'b1, 7'd64, 7'd0, 1'b0));
        add_row(ROW_CFG, CMD_LINE_RX, 8'h00, 7'd0, 1'b1, 1, '0);
        add_row(ROW_REQ, CMD_HOST_RD, 8'h00, 7'd0, 1'b0, DEPTH, '0);
        add_row(ROW_REQ_FIXED, CMD_HOST_RD, 8'h00, 7'd0, 1'b0, 1,
                make_result(ST_EMPTY, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_WR_CHECK, 8'h00, 7'd64, 1'b0, 1,
                make_result(ST_OK, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_WR_CHECK, 8'h00, 7'd65, 1'b0, 1,
                make_result(ST_NOROOM, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_WR_CHECK, 8'hFF, 7'd127, 1'b1, 1,
                make_result(ST_NOROOM, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0));
        // fill the transmit ring with the transmitter idle
        add_row(ROW_REQ, CMD_WR_BYTE, 8'h80, 7'd0, 1'b0, DEPTH, '0);
        add_row(ROW_REQ_FIXED, CMD_WR_CHECK, 8'h00, 7'd1, 1'b0, 1,
                make_result(ST_NOROOM, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0, 7'd64, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_WR_CHECK, 8'h00, 7'd0, 1'b0, 1,
                make_result(ST_OK, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0, 7'd64, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_WR_BYTE, 8'h55, 7'd0, 1'b0, 1,
                make_result(ST_NOROOM, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0, 7'd64, 1'b0));
        // byte dropped but the kick still goes out with the oldest byte
        add_row(ROW_REQ_FIXED, CMD_WR_BYTE, 8'hAA, 7'd0, 1'b1, 1,
                make_result(ST_NOROOM, 8'h00, 1'b1, 8'h80, 1'b1, 7'd0, 7'd63, 1'b1));
        add_row(ROW_REQ, CMD_TX_READY, 8'h00, 7'd0, 1'b0, DEPTH - 1, '0);
        add_row(ROW_REQ_FIXED, CMD_TX_READY, 8'h00, 7'd0, 1'b0, 1,
                make_result(ST_OK, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_TX_READY, 8'hFF, 7'd127, 1'b1, 1,
                make_result(ST_OK, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0));
        add_row(ROW_REQ_FIXED, CMD_SPARE_5, 8'hFF, 7'd127, 1'b1, 1,
                make_result(ST_OK, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0));
        add_row(ROW_REQ, CMD_SPARE_6, 8'h5A, 7'd42, 1'b0, 1, '0);
        add_row(ROW_REQ, CMD_SPARE_7, 8'hA5, 7'd85, 1'b1, 1, '0);
        add_row(ROW_REQ_FIXED, CMD_WR_BYTE, 8'h3C, 7'd0, 1'b1, 1,
                make_result(ST_OK, 8'h00, 1'b1, 8'h3C, 1'b1, 7'd0, 7'd0, 1'b1));
        add_row(ROW_REQ, CMD_TX_READY, 8'h00, 7'd0, 1'b0, 1, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_port_open(row.last);
            end else begin
                for (k = 0; k < row.reps; k++)
                    send_req(row.cmd, 8'(row.data + k), row.len, row.last,
                             row.kind == ROW_REQ_FIXED, row.want);
            end
        end

        base  = n_sent;
        phase = 0;
        while (n_sent - base < RANDOM_REQS) begin
            wait_drained();
            write_port_open(phase % 4 != 2);
            phase_len = $urandom_range(80, 200);
            phase_end = n_sent + phase_len;
            while (n_sent < phase_end) begin
                steady = (n_sent - base >= 700) && (n_sent - base < 1000);
                sel = $urandom_range(99);
                if (sel < 35) begin
                    // host message: check, then bytes with last on the final one, unless broken
                    n = ($urandom_range(7) == 0) ? $urandom_range(1, DEPTH)
                                                 : $urandom_range(1, 8);
                    broken = ($urandom_range(9) == 0);
                    last_pred.status = ST_OK;
                    if (!broken || $urandom_range(1))
                        send_req(CMD_WR_CHECK, 8'($urandom_range(255)), 7'(n),
                                 1'($urandom_range(1)));
                    if (broken || last_pred.status == ST_OK) begin
                        for (k = 0; k < n; k++) begin
                            lst = broken ? 1'($urandom_range(1)) : (k == n - 1);
                            send_req(CMD_WR_BYTE, 8'($urandom_range(255)),
                                     7'($urandom_range(127)), lst);
                        end
                    end
                end else if (sel < 88) begin
                    if (sel < 55)
                        k = CMD_LINE_RX;
                    else if (sel < 70)
                        k = CMD_HOST_RD;
                    else
                        k = CMD_TX_READY;
                    n = ($urandom_range(9) == 0) ? $urandom_range(DEPTH, DEPTH + 6)
                                                 : $urandom_range(1, 12);
                    repeat (n)
                        send_req(3'(k), 8'($urandom_range(255)), 7'($urandom_range(127)),
                                 1'($urandom_range(1)));
                end else begin
                    repeat ($urandom_range(1, 4))
                        send_req(3'($urandom_range(7)), 8'($urandom_range(255)),
                                 7'($urandom_range(127)), 1'($urandom_range(1)));
                end
                // now and then hold the host off until everything is back
                if ($urandom_range(39) == 0)
                    wait_drained();
            end
            phase++;
        end
        steady = 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("%0d requests over %0d port settings, %0d results checked",
                 n_sent, phase + 2, n_checked);
        $display("%0d bytes to the transmitter, %0d host reads, %0d receive overruns",
                 n_tx_bytes, n_reads, n_drops);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
